>>> sv/ststab_pkg.sv
package ststab_pkg;

	// operation codes carried by the input item
	localparam logic [1:0] MODE_SET    = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;
	localparam logic [1:0] MODE_NEXT   = 2'd3;

	// result status codes
	localparam logic [1:0] STAT_DONE     = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_NOTFOUND = 2'd2;

	localparam logic [8:0] LINE_WIDTH_RESET = 9'd80;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] column;
	} item_t;

	// packed so that next_column sits in the lowest bits
	typedef struct packed {
		logic [5:0] stop_count;
		logic [1:0] status;
		logic [7:0] next_column;
	} res_t;

endpackage

>>> sv/ststab_ram.sv
module ststab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/ststab_ctrl.sv
module ststab_ctrl import ststab_pkg::*; #(
	parameter int TABLE_DEPTH = 32,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  item_t         in_item,
	input  logic [8:0]    line_width,
	input  logic          out_free,
	output logic          res_valid,
	output res_t          res,
	output logic          ram_we,
	output logic [AW-1:0] ram_waddr,
	output logic [7:0]    ram_wdata,
	output logic [AW-1:0] ram_raddr,
	input  logic [7:0]    ram_rdata
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SEARCH = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_SHUP   = 3'd3;
	localparam logic [2:0] ST_INS    = 3'd4;
	localparam logic [2:0] ST_SHDN   = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;

	logic [2:0]    state_q;
	item_t         item_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] cnt_q;
	logic [7:0]    val_q;
	logic [AW-1:0] ptr_q;
	logic [7:0]    next_q;
	logic [1:0]    status_q;

	logic          found;
	logic          match;
	logic [7:0]    miss_col;

	assign found = idx_q < cnt_q;
	assign match = found && (val_q == item_q.column);

	// no stop at or after the cursor: line width minus one, saturated
	always_comb begin
		if (line_width == 9'd0) begin
			miss_col = 8'd0;
		end else if (line_width > 9'd256) begin
			miss_col = 8'hff;
		end else begin
			miss_col = 8'(line_width - 9'd1);
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = ram_rdata;
		ram_raddr = '0;
		case (state_q)
			ST_SEARCH: ram_raddr = AW'(idx_q + CW'(1));
			ST_DECIDE: begin
				if (item_q.mode == MODE_SET) begin
					ram_raddr = AW'(cnt_q - CW'(1));
				end else begin
					ram_raddr = AW'(idx_q + CW'(1));
				end
			end
			ST_SHUP: begin
				ram_we    = 1'b1;
				ram_raddr = ptr_q - AW'(2);
			end
			ST_INS: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(idx_q);
				ram_wdata = item_q.column;
			end
			ST_SHDN: begin
				ram_we    = 1'b1;
				ram_raddr = ptr_q + AW'(2);
			end
			default: ram_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q   <= in_item;
						idx_q    <= '0;
						next_q   <= 8'd0;
						status_q <= STAT_DONE;
						if (in_item.mode == MODE_CLEAR) begin
							cnt_q   <= '0;
							state_q <= ST_FIN;
						end else if (cnt_q == '0) begin
							state_q <= ST_DECIDE;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (ram_rdata >= item_q.column) begin
						val_q   <= ram_rdata;
						state_q <= ST_DECIDE;
					end else begin
						idx_q <= idx_q + CW'(1);
						if (idx_q + CW'(1) == cnt_q) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					case (item_q.mode)
						MODE_SET: begin
							if (match) begin
								state_q <= ST_FIN;
							end else if (cnt_q >= CW'(TABLE_DEPTH)) begin
								status_q <= STAT_FULL;
								state_q  <= ST_FIN;
							end else if (idx_q == cnt_q) begin
								state_q <= ST_INS;
							end else begin
								ptr_q   <= AW'(cnt_q);
								state_q <= ST_SHUP;
							end
						end
						MODE_REMOVE: begin
							if (!match) begin
								status_q <= STAT_NOTFOUND;
								state_q  <= ST_FIN;
							end else if (idx_q + CW'(1) == cnt_q) begin
								cnt_q   <= cnt_q - CW'(1);
								state_q <= ST_FIN;
							end else begin
								ptr_q   <= AW'(idx_q);
								state_q <= ST_SHDN;
							end
						end
						default: begin
							next_q  <= found ? val_q : miss_col;
							state_q <= ST_FIN;
						end
					endcase
				end
				ST_SHUP: begin
					if (CW'(ptr_q) == idx_q + CW'(1)) begin
						state_q <= ST_INS;
					end else begin
						ptr_q <= ptr_q - AW'(1);
					end
				end
				ST_INS: begin
					cnt_q   <= cnt_q + CW'(1);
					state_q <= ST_FIN;
				end
				ST_SHDN: begin
					if (CW'(ptr_q) + CW'(2) == cnt_q) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= ST_FIN;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready        = (state_q == ST_IDLE);
	assign res_valid       = (state_q == ST_FIN);
	assign res.next_column = next_q;
	assign res.status      = status_q;
	assign res.stop_count  = 6'(cnt_q);

endmodule

>>> sv/sorted_tab_stop_table_unit.sv
// Sorted tab stop table. Holds up to TABLE_DEPTH distinct tab stop columns in ascending
// order in a single-port-write, registered-read RAM, plus a held-stop count. Each input
// item (mode on s_tuser, column on s_tdata) gives exactly one result item: set inserts a
// stop in order (a stop already present is left alone, a full table refuses with status 1),
// remove deletes a stop and closes the gap (status 2 if absent), clear empties the table,
// and next returns the first stop at or after the column, or line_width - 1 (saturated to
// 255, 0 for width 0) when none follows. The RAM port sets the rate: a search reads one
// entry per cycle and stops at the first entry not below the column, and an insert or
// delete then moves one entry per cycle. A result that finds the output register full waits
// in the controller until it drains. The table needs no clearing pass after reset. A
// finished result waits in the output register while the next item is taken. line_width
// is written through cfg_we / cfg_wdata; the user must write it only while idle, as the
// block itself does not enforce this.
module sorted_tab_stop_table_unit import ststab_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: line_width
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] column
	input  logic [1:0]  s_tuser,   // [1:0] mode
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [7:0] next_column, [9:8] status, [15:10] stop_count
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [8:0]    line_width_q;
	logic          m_valid_q;
	res_t          m_data_q;

	item_t         item;
	res_t          res;
	logic          res_valid;
	logic          out_free;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RESET;
		end else if (cfg_we) begin
			line_width_q <= cfg_wdata;
		end
	end

	assign item.mode   = s_tuser;
	assign item.column = s_tdata;

	// output slot can take a new result when empty or being drained this cycle
	assign out_free = !m_valid_q || m_tready;

	ststab_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (item),
		.line_width(line_width_q),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// stop store: contents undefined until written, only entries below the count are used
	ststab_ram #(
		.WIDTH(8),
		.DEPTH(TABLE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			m_data_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
	// s_tready drops after each accepted item, so no two items are taken back to back
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on back-to-back cycles");

	// a finished result moves into a free output slot
	a_result_moves: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_free |=> m_tvalid && !res_valid)
		else $error("finished result did not reach the output register");

	// held count never exceeds the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (int'(res.stop_count) <= TABLE_DEPTH))
		else $error("stop count beyond table depth");

	// a refused set only happens with the table full
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == STAT_FULL) |-> (int'(res.stop_count) == TABLE_DEPTH % 64))
		else $error("full status with free entries");
`endif

endmodule
